[sv/nm3i_pkg.sv]
`default_nettype none
package nm3i_pkg;

    localparam int unsigned NUM_ELEM  = 9;
    localparam int unsigned ELEM_W    = 32;
    localparam int unsigned PROD_W    = 64;
    localparam int unsigned COF_W     = 65;
    localparam int unsigned DET_W     = 97;
    localparam int unsigned THR_W     = 31;
    localparam int unsigned Q_BITS    = 34;
    localparam int unsigned REM_W     = DET_W + 1;
    localparam int unsigned PRE_SHIFT = 48 - Q_BITS;

    // Operand indexes a, b, c, d of each cofactor a*b - c*d.
    localparam logic [3:0] COF_IDX [NUM_ELEM][4] = '{
        '{4'd4, 4'd8, 4'd5, 4'd7},
        '{4'd5, 4'd6, 4'd3, 4'd8},
        '{4'd3, 4'd7, 4'd4, 4'd6},
        '{4'd2, 4'd7, 4'd1, 4'd8},
        '{4'd0, 4'd8, 4'd2, 4'd6},
        '{4'd1, 4'd6, 4'd0, 4'd7},
        '{4'd1, 4'd5, 4'd2, 4'd4},
        '{4'd2, 4'd3, 4'd0, 4'd5},
        '{4'd0, 4'd4, 4'd1, 4'd3}
    };

    localparam logic [DET_W-1:0] DET_ONE = DET_W'(1) << 72;
    localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_NEG = 32'h8000_0000;

    typedef logic [NUM_ELEM-1:0][ELEM_W-1:0] t_mat;

    typedef struct packed {
        logic [NUM_ELEM-1:0][PROD_W-1:0] cof_abs;
        logic [NUM_ELEM-1:0]             cof_neg;
        logic [DET_W-1:0]                det_abs;
        logic                            det_neg;
        logic                            sing;
    } t_job;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FIN
    } t_state;

endpackage
`default_nettype wire

[sv/normal_matrix_3x3_inverse_top.sv]
// Normal matrix (inverse transpose) of a 3x3 Q8.24 matrix, by adjugate.
// Input: an item is taken on a rising edge with start high and busy low;
// the nine elements i_in_rXcY are sampled on that edge.
// Configuration: i_cfg_we writes i_cfg_wdata into the determinant
// threshold; write it only while no item is in flight.
// Output: o_strobe is high for one cycle with the nine o_out_rXcY
// elements and o_singular_flag; the receiver cannot hold results off.
// Datapath: a four-stage front computes cofactors and the determinant,
// then a queue of QUEUE_DEPTH items feeds the back end, whose nine
// restoring dividers run 34 iterations and then a rounding step.
// The shared iterative divider bank works on one item at a time and
// takes the next from the queue as it finishes; the front and queue
// hold up to QUEUE_DEPTH items and take one per cycle while busy is low.
// busy is high when every queue slot is reserved by an item in flight.
// Reset clears the pipeline valid flags, the queue pointers and the
// divider control state, and sets the threshold to 17.
`default_nettype none
module normal_matrix_3x3_inverse_top #(
    parameter int unsigned QUEUE_DEPTH = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               i_cfg_we,
    input  wire logic [30:0]        i_cfg_wdata,
    input  wire logic signed [31:0] i_in_r0c0,
    input  wire logic signed [31:0] i_in_r0c1,
    input  wire logic signed [31:0] i_in_r0c2,
    input  wire logic signed [31:0] i_in_r1c0,
    input  wire logic signed [31:0] i_in_r1c1,
    input  wire logic signed [31:0] i_in_r1c2,
    input  wire logic signed [31:0] i_in_r2c0,
    input  wire logic signed [31:0] i_in_r2c1,
    input  wire logic signed [31:0] i_in_r2c2,
    output logic                    o_strobe,
    output logic signed [31:0]      o_out_r0c0,
    output logic signed [31:0]      o_out_r0c1,
    output logic signed [31:0]      o_out_r0c2,
    output logic signed [31:0]      o_out_r1c0,
    output logic signed [31:0]      o_out_r1c1,
    output logic signed [31:0]      o_out_r1c2,
    output logic signed [31:0]      o_out_r2c0,
    output logic signed [31:0]      o_out_r2c1,
    output logic signed [31:0]      o_out_r2c2,
    output logic                    o_singular_flag
);

    localparam int unsigned UW = $clog2(QUEUE_DEPTH + 1);

    logic [nm3i_pkg::THR_W-1:0] r_thr;
    logic [UW-1:0] r_used;
    logic accept, push, pop, empty;
    nm3i_pkg::t_mat in_mat, out_mat;
    nm3i_pkg::t_job f_job, q_job;

    assign busy   = (r_used == UW'(QUEUE_DEPTH));
    assign accept = start && !busy;
    assign in_mat = {i_in_r2c2, i_in_r2c1, i_in_r2c0, i_in_r1c2, i_in_r1c1,
                     i_in_r1c0, i_in_r0c2, i_in_r0c1, i_in_r0c0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr  <= nm3i_pkg::THR_W'(17);
            r_used <= '0;
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
            r_used <= r_used + UW'(accept) - UW'(pop);
        end
    end

    nm3i_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_mat    (in_mat),
        .i_thr    (r_thr),
        .o_push   (push),
        .o_job    (f_job)
    );

    nm3i_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (f_job),
        .i_pop   (pop),
        .o_empty (empty),
        .o_job   (q_job)
    );

    nm3i_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_job   (q_job),
        .o_pop   (pop),
        .o_valid (o_strobe),
        .o_mat   (out_mat),
        .o_sing  (o_singular_flag)
    );

    assign o_out_r0c0 = out_mat[0];
    assign o_out_r0c1 = out_mat[1];
    assign o_out_r0c2 = out_mat[2];
    assign o_out_r1c0 = out_mat[3];
    assign o_out_r1c1 = out_mat[4];
    assign o_out_r1c2 = out_mat[5];
    assign o_out_r2c0 = out_mat[6];
    assign o_out_r2c1 = out_mat[7];
    assign o_out_r2c2 = out_mat[8];

endmodule
`default_nettype wire

[sv/nm3i_front.sv]
`default_nettype none
module nm3i_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_accept,
    input  wire nm3i_pkg::t_mat                 i_mat,
    input  wire logic [nm3i_pkg::THR_W-1:0]     i_thr,
    output logic                                o_push,
    output nm3i_pkg::t_job                      o_job
);

    localparam int unsigned N  = nm3i_pkg::NUM_ELEM;
    localparam int unsigned CW = nm3i_pkg::COF_W;
    localparam int unsigned DW = nm3i_pkg::DET_W;

    logic r_v1, r_v2, r_v3, r_v4;

    logic signed [31:0] r_m1 [3];
    logic signed [31:0] r_m2 [3];
    logic signed [63:0] r_p  [2*N];
    logic signed [CW-1:0] r_c [N];
    logic [N-1:0][63:0] r_ca3, r_ca4;
    logic [N-1:0]       r_cn3, r_cn4;
    logic signed [CW-1:0] r_pl [3];
    logic signed [CW-1:0] r_ph [3];
    logic [DW-1:0] r_det;

    logic [DW-1:0] det_abs;
    logic          det_tiny;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_accept;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < N; j++) begin
            r_p[2*j]   <= $signed(i_mat[nm3i_pkg::COF_IDX[j][0]])
                        * $signed(i_mat[nm3i_pkg::COF_IDX[j][1]]);
            r_p[2*j+1] <= $signed(i_mat[nm3i_pkg::COF_IDX[j][2]])
                        * $signed(i_mat[nm3i_pkg::COF_IDX[j][3]]);
        end
        for (int k = 0; k < 3; k++) begin
            r_m1[k] <= $signed(i_mat[k]);
            r_m2[k] <= r_m1[k];
        end
        for (int j = 0; j < N; j++) begin
            r_c[j] <= CW'(r_p[2*j]) - CW'(r_p[2*j+1]);
        end
        for (int j = 0; j < N; j++) begin
            r_cn3[j] <= r_c[j][CW-1];
            r_ca3[j] <= r_c[j][CW-1] ? 64'(-r_c[j]) : 64'(r_c[j]);
        end
        for (int k = 0; k < 3; k++) begin
            r_pl[k] <= r_m2[k] * $signed({1'b0, r_c[k][31:0]});
            r_ph[k] <= r_m2[k] * $signed(r_c[k][CW-1:32]);
        end
        r_ca4 <= r_ca3;
        r_cn4 <= r_cn3;
        r_det <= {r_ph[0], 32'b0} + {r_ph[1], 32'b0} + {r_ph[2], 32'b0}
               + {{(DW-CW){r_pl[0][CW-1]}}, r_pl[0]}
               + {{(DW-CW){r_pl[1][CW-1]}}, r_pl[1]}
               + {{(DW-CW){r_pl[2][CW-1]}}, r_pl[2]};
    end

    always_comb begin
        det_abs  = r_det[DW-1] ? (~r_det + DW'(1)) : r_det;
        det_tiny = (det_abs < DW'({i_thr, 48'b0})) || (det_abs == '0);
        o_push   = r_v4;
        o_job.cof_abs = r_ca4;
        o_job.cof_neg = r_cn4;
        o_job.sing    = det_tiny;
        o_job.det_abs = det_tiny ? nm3i_pkg::DET_ONE : det_abs;
        o_job.det_neg = det_tiny ? 1'b0 : r_det[DW-1];
    end

endmodule
`default_nettype wire

[sv/nm3i_fifo.sv]
`default_nettype none
module nm3i_fifo #(
    parameter int unsigned DEPTH = 8
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire nm3i_pkg::t_job i_job,
    input  wire logic           i_pop,
    output logic                o_empty,
    output nm3i_pkg::t_job      o_job
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    nm3i_pkg::t_job r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
            end
            r_cnt <= r_cnt + CW'(i_push) - CW'(i_pop);
        end
    end

    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rp];

endmodule
`default_nettype wire

[sv/nm3i_back.sv]
`default_nettype none
module nm3i_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_empty,
    input  wire nm3i_pkg::t_job i_job,
    output logic                o_pop,
    output logic                o_valid,
    output nm3i_pkg::t_mat      o_mat,
    output logic                o_sing
);

    localparam int unsigned N  = nm3i_pkg::NUM_ELEM;
    localparam int unsigned RW = nm3i_pkg::REM_W;
    localparam int unsigned QB = nm3i_pkg::Q_BITS;
    localparam int unsigned DW = nm3i_pkg::DET_W;
    localparam int unsigned KW = $clog2(QB);

    nm3i_pkg::t_state r_state, n_state;
    logic [KW-1:0] r_cnt;
    logic [RW-1:0] r_rem [N];
    logic [QB-1:0] r_q   [N];
    logic [N-1:0]  r_sat, r_neg;
    logic [DW-1:0] r_da;
    logic          r_sing;

    logic load;
    logic [RW-1:0] sh   [N];
    logic [RW-1:0] init [N];
    logic [QB:0]   qf   [N];

    always_comb begin
        n_state = r_state;
        load    = 1'b0;
        case (r_state)
            nm3i_pkg::ST_IDLE: begin
                if (!i_empty) begin
                    load    = 1'b1;
                    n_state = nm3i_pkg::ST_RUN;
                end
            end
            nm3i_pkg::ST_RUN: begin
                if (r_cnt == KW'(QB - 1)) begin
                    n_state = nm3i_pkg::ST_FIN;
                end
            end
            nm3i_pkg::ST_FIN: begin
                if (!i_empty) begin
                    load    = 1'b1;
                    n_state = nm3i_pkg::ST_RUN;
                end else begin
                    n_state = nm3i_pkg::ST_IDLE;
                end
            end
            default: n_state = nm3i_pkg::ST_IDLE;
        endcase
        o_pop = load;
        for (int i = 0; i < N; i++) begin
            sh[i]   = {r_rem[i][RW-2:0], 1'b0};
            init[i] = RW'({i_job.cof_abs[i], nm3i_pkg::PRE_SHIFT'(0)});
            qf[i]   = {1'b0, r_q[i]} + (QB+1)'(sh[i] >= RW'(r_da));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nm3i_pkg::ST_IDLE;
            r_cnt   <= '0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= load ? '0 : r_cnt + KW'(1);
            o_valid <= (r_state == nm3i_pkg::ST_FIN);
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_da   <= i_job.det_abs;
            r_sing <= i_job.sing;
            for (int i = 0; i < N; i++) begin
                r_rem[i] <= init[i];
                r_q[i]   <= '0;
                r_sat[i] <= init[i] >= RW'(i_job.det_abs);
                r_neg[i] <= i_job.cof_neg[i] ^ i_job.det_neg;
            end
        end else if (r_state == nm3i_pkg::ST_RUN) begin
            for (int i = 0; i < N; i++) begin
                if (sh[i] >= RW'(r_da)) begin
                    r_rem[i] <= sh[i] - RW'(r_da);
                    r_q[i]   <= {r_q[i][QB-2:0], 1'b1};
                end else begin
                    r_rem[i] <= sh[i];
                    r_q[i]   <= {r_q[i][QB-2:0], 1'b0};
                end
            end
        end
        if (r_state == nm3i_pkg::ST_FIN) begin
            o_sing <= r_sing;
            for (int i = 0; i < N; i++) begin
                if (r_neg[i]) begin
                    o_mat[i] <= (r_sat[i] || qf[i] > (QB+1)'(nm3i_pkg::SAT_NEG))
                              ? nm3i_pkg::SAT_NEG : 32'(-qf[i]);
                end else begin
                    o_mat[i] <= (r_sat[i] || qf[i] > (QB+1)'(nm3i_pkg::SAT_POS))
                              ? nm3i_pkg::SAT_POS : qf[i][31:0];
                end
            end
        end
    end

endmodule
`default_nettype wire

[test/normal_matrix_3x3_inverse_top_tb.sv]
`timescale 1ns / 100ps
`default_nettype none
module normal_matrix_3x3_inverse_top_tb;

    typedef struct {
        nm3i_pkg::t_mat elem;
        logic flag;
    } t_normal;

    typedef struct {
        nm3i_pkg::t_mat mat;
        bit   typed;
        nm3i_pkg::t_mat exp_mat;
        logic exp_flag;
    } t_row;

    localparam logic [31:0] ONE  = 32'h0100_0000;
    localparam logic [31:0] HALF = 32'h0080_0000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic i_cfg_we = 1'b0;
    logic [30:0] i_cfg_wdata = '0;
    nm3i_pkg::t_mat in_mat = '0;
    logic o_strobe;
    logic signed [31:0] o_out_r0c0, o_out_r0c1, o_out_r0c2;
    logic signed [31:0] o_out_r1c0, o_out_r1c1, o_out_r1c2;
    logic signed [31:0] o_out_r2c0, o_out_r2c1, o_out_r2c2;
    logic o_singular_flag;

    logic [30:0] threshold = 31'd17;
    t_normal pending[$];
    int errors = 0;
    int idle_pct = 0;

    always #5 i_clk = ~i_clk;

    normal_matrix_3x3_inverse_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_in_r0c0(in_mat[0]), .i_in_r0c1(in_mat[1]), .i_in_r0c2(in_mat[2]),
        .i_in_r1c0(in_mat[3]), .i_in_r1c1(in_mat[4]), .i_in_r1c2(in_mat[5]),
        .i_in_r2c0(in_mat[6]), .i_in_r2c1(in_mat[7]), .i_in_r2c2(in_mat[8]),
        .o_strobe(o_strobe),
        .o_out_r0c0(o_out_r0c0), .o_out_r0c1(o_out_r0c1), .o_out_r0c2(o_out_r0c2),
        .o_out_r1c0(o_out_r1c0), .o_out_r1c1(o_out_r1c1), .o_out_r1c2(o_out_r1c2),
        .o_out_r2c0(o_out_r2c0), .o_out_r2c1(o_out_r2c1), .o_out_r2c2(o_out_r2c2),
        .o_singular_flag(o_singular_flag)
    );

    function automatic logic signed [127:0] minor(logic signed [127:0] a,
            logic signed [127:0] b, logic signed [127:0] c, logic signed [127:0] d);
        return a * b - c * d;
    endfunction

    function automatic t_normal normal_of(nm3i_pkg::t_mat a, logic [30:0] thr);
        logic signed [127:0] m [9];
        logic signed [127:0] c [9];
        logic signed [127:0] det;
        logic [127:0] da, ca, num, q, r;
        t_normal res;
        for (int i = 0; i < 9; i++) m[i] = {{96{a[i][31]}}, a[i]};
        c[0] = minor(m[4], m[8], m[5], m[7]);
        c[1] = minor(m[5], m[6], m[3], m[8]);
        c[2] = minor(m[3], m[7], m[4], m[6]);
        c[3] = minor(m[2], m[7], m[1], m[8]);
        c[4] = minor(m[0], m[8], m[2], m[6]);
        c[5] = minor(m[1], m[6], m[0], m[7]);
        c[6] = minor(m[1], m[5], m[2], m[4]);
        c[7] = minor(m[2], m[3], m[0], m[5]);
        c[8] = minor(m[0], m[4], m[1], m[3]);
        det = m[0] * c[0] + m[1] * c[1] + m[2] * c[2];
        da = det < 0 ? -det : det;
        res.flag = (da < ({97'd0, thr} << 48)) || (da == 0);
        if (res.flag) begin
            det = 128'd1 << 72;
            da = det;
        end
        for (int k = 0; k < 9; k++) begin
            ca = c[k] < 0 ? -c[k] : c[k];
            num = ca << 48;
            q = num / da;
            r = num % da;
            if ((r << 1) >= da) q = q + 1;
            if ((c[k] < 0) != (det < 0)) begin
                res.elem[k] = (q > 128'h8000_0000) ? nm3i_pkg::SAT_NEG : 32'(-q);
            end else begin
                res.elem[k] = (q > 128'h7FFF_FFFF) ? nm3i_pkg::SAT_POS : q[31:0];
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        nm3i_pkg::t_mat got;
        t_normal want;
        if (i_rst_n && o_strobe) begin
            got = {o_out_r2c2, o_out_r2c1, o_out_r2c0, o_out_r1c2, o_out_r1c1,
                   o_out_r1c0, o_out_r0c2, o_out_r0c1, o_out_r0c0};
            if (pending.size() == 0) begin
                $error("unexpected result item");
                errors++;
            end else begin
                want = pending.pop_front();
                for (int k = 0; k < 9; k++) begin
                    if (got[k] !== want.elem[k]) begin
                        $error("out_r%0dc%0d expected %h actual %h",
                               k / 3, k % 3, want.elem[k], got[k]);
                        errors++;
                    end
                end
                if (o_singular_flag !== want.flag) begin
                    $error("singular_flag expected %b actual %b",
                           want.flag, o_singular_flag);
                    errors++;
                end
            end
        end
    end

    task automatic send(nm3i_pkg::t_mat mat, t_normal want);
        int gap;
        start <= 1'b1;
        in_mat <= mat;
        do @(posedge i_clk); while (busy);
        pending.push_back(want);
        gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 4) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending.size() > 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic set_threshold(logic [30:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        threshold = v;
        @(posedge i_clk);
    endtask

    function automatic nm3i_pkg::t_mat diag(logic [31:0] a, logic [31:0] b,
                                            logic [31:0] c);
        nm3i_pkg::t_mat r = '0;
        r[0] = a;
        r[4] = b;
        r[8] = c;
        return r;
    endfunction

    function automatic nm3i_pkg::t_mat random_mat(int kind);
        nm3i_pkg::t_mat r;
        for (int i = 0; i < 9; i++) begin
            case (kind)
                0: r[i] = $urandom;
                1: r[i] = $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
                default: r[i] = $urandom_range(0, 32'h0001_0000) - 32'h0000_8000;
            endcase
        end
        if ($urandom_range(7) == 0) begin
            for (int i = 0; i < 3; i++) r[6 + i] = r[i];
        end
        return r;
    endfunction

    initial begin
        #5ms;
        $display("normal_matrix_3x3_inverse_top_tb NOT OK");
        $finish;
    end

    initial begin
        t_row rows [$];
        t_row row;
        nm3i_pkg::t_mat mat;
        logic [30:0] thr_list [3];
        int pcts [3];

        row = '{diag(ONE, ONE, ONE), 1, diag(ONE, ONE, ONE), 1'b0};
        rows.push_back(row);
        row = '{'0, 1, '0, 1'b1};
        rows.push_back(row);
        row = '{diag(2 * ONE, 2 * ONE, 2 * ONE), 1, diag(HALF, HALF, HALF), 1'b0};
        rows.push_back(row);
        row = '{{9{32'h7FFF_FFFF}}, 1, '0, 1'b1};
        rows.push_back(row);
        row = '{{9{32'h8000_0000}}, 1, '0, 1'b1};
        rows.push_back(row);
        row = '{diag(-ONE, ONE, ONE), 1, diag(-ONE, ONE, ONE), 1'b0};
        rows.push_back(row);
        mat = diag(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        row = '{mat, 0, '0, 1'b0};
        rows.push_back(row);
        row.mat = diag(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        rows.push_back(row);
        row.mat = diag(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        rows.push_back(row);
        row.mat = diag(32'd1, ONE, ONE);
        rows.push_back(row);
        row.mat = diag(32'd17, 32'd1 << 24, 32'd1 << 24);
        rows.push_back(row);
        row.mat = diag(32'd16, 32'd1 << 24, 32'd1 << 24);
        rows.push_back(row);
        row.mat = diag(ONE, ONE, 32'h100);
        rows.push_back(row);
        row.mat = diag(ONE, -ONE, -32'h100);
        rows.push_back(row);
        row.mat = diag(ONE, ONE, 32'h7FFF_FFFF);
        rows.push_back(row);
        row.mat = '{32'h0300_0000, 32'h0100_0000, 32'hFF00_0000, 32'h0200_0000,
                    32'h0500_0000, 32'h0100_0000, 32'h0000_8000, 32'hFE00_0000,
                    32'h0400_0000};
        rows.push_back(row);
        row.mat = '{32'hFFFF_FFFF, 32'h8000_0001, 32'h7FFF_FFFE, 32'h1234_5678,
                    32'hEDCB_A987, 32'h0000_0001, 32'h5555_5555, 32'hAAAA_AAAA,
                    32'h0F0F_0F0F};
        rows.push_back(row);

        thr_list = '{31'd0, 31'h7FFF_FFFF, 31'($urandom_range(0, 32'h0010_0000))};
        pcts = '{33, 54, 0};

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idle_pct = 33;
        foreach (rows[i]) begin
            t_normal want;
            want = normal_of(rows[i].mat, threshold);
            if (rows[i].typed) begin
                want.elem = rows[i].exp_mat;
                want.flag = rows[i].exp_flag;
            end
            send(rows[i].mat, want);
        end
        drain();

        for (int p = 0; p < 3; p++) begin
            set_threshold(thr_list[p]);
            idle_pct = pcts[p];
            repeat (165) begin
                mat = random_mat($urandom_range(2));
                send(mat, normal_of(mat, threshold));
            end
            drain();
        end

        if (errors == 0) begin
            $display("normal_matrix_3x3_inverse_top_tb OK");
        end else begin
            $display("normal_matrix_3x3_inverse_top_tb NOT OK");
        end
        $finish;
    end
endmodule
`default_nettype wire
